@@ rtl/abpm_pkg.sv @@
// Package for the audio block peak and power moments block.
// Holds field widths, the period limits and the shared multiplier widths.
// No dependencies.
package abpm_pkg;

	localparam int SAMPLE_BITS = 16;  // low bits of the sample field in use
	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 15;
	localparam int CFG_W       = 4;
	localparam int ABS_ACC_W   = 31;
	localparam int SQR_ACC_W   = 46;
	localparam int CUBE_ACC_W  = 45;
	localparam int QUAD_ACC_W  = 44;
	localparam int MAG_W       = 16;  // |x| up to 2^15
	localparam int MUL_W       = 31;  // x^2 up to 2^30
	localparam int PROD_W      = 2 * MUL_W;
	localparam int CUBE_SHIFT  = 16;
	localparam int QUAD_SHIFT  = 32;

	localparam logic [CFG_W-1:0] PERIOD_LOG2_MIN   = 4'd3;
	localparam logic [CFG_W-1:0] PERIOD_LOG2_RESET = 4'd14;

endpackage

@@ rtl/abpm_in_if.sv @@
// Sample channel: valid/ready handshake with sample and restart payload.
// Depends on abpm_pkg.
interface abpm_in_if;
	import abpm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);

endinterface

@@ rtl/abpm_out_if.sv @@
// Result channel: valid/ready handshake with the per-block statistics.
// Depends on abpm_pkg.
interface abpm_out_if;
	import abpm_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [POS_W-1:0]             peak_high;
	logic signed [SAMPLE_W-1:0]   peak_low;
	logic [POS_W-1:0]             peak_high_offset;
	logic [POS_W-1:0]             peak_low_offset;
	logic [ABS_ACC_W-1:0]         sum_abs;
	logic [SQR_ACC_W-1:0]         sum_square;
	logic [CUBE_ACC_W-1:0]        sum_cube_scaled;
	logic [QUAD_ACC_W-1:0]        sum_fourth_scaled;

	modport source (output valid, output peak_high, output peak_low,
		output peak_high_offset, output peak_low_offset, output sum_abs,
		output sum_square, output sum_cube_scaled, output sum_fourth_scaled,
		input ready);
	modport sink (input valid, input peak_high, input peak_low,
		input peak_high_offset, input peak_low_offset, input sum_abs,
		input sum_square, input sum_cube_scaled, input sum_fourth_scaled,
		output ready);

endinterface

@@ rtl/audio_block_peak_and_moments.sv @@
// Top level of the audio block peak detector and power moments block.
// Depends on abpm_pkg, abpm_in_if and abpm_out_if.
//
//   channel   dir  handshake        payload
//   samples   in   valid / ready    sample[15:0] signed, restart
//   results   out  valid / ready    peaks, peak offsets, four moment sums
//   cfg       in   cfg_we           cfg_wdata[3:0] = period_log2
//
// A warm-up or restart item (first half period after reset or restart) is handled in the idle state alone.
// A counted item steps through accept, then x^2, x^3 and x^4 in turn on the one
// shared 31x31 multiplier, then the last accumulate.
// The block end item loads the output register in its last cycle; if the
// previous result still sits there unread, hold in a wait state until it goes.
// arst_n clears control state, statistics and the period register (14).
module audio_block_peak_and_moments (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [abpm_pkg::CFG_W-1:0]  cfg_wdata,
	abpm_in_if.sink                     samples,
	abpm_out_if.source                  results
);
	import abpm_pkg::*;

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL0 = 3'd1;  // |x| * |x|
	localparam logic [2:0] S_MUL1 = 3'd2;  // x^2 * |x|, add x^2
	localparam logic [2:0] S_MUL2 = 3'd3;  // x^2 * x^2, add cube
	localparam logic [2:0] S_MUL3 = 3'd4;  // add fourth, maybe emit
	localparam logic [2:0] S_WAIT = 3'd5;  // block done, output busy

	logic [2:0]                 state_q;
	logic [CFG_W-1:0]           period_log2_q;
	logic                       warm_q;
	logic [POS_W-1:0]           pos_q;
	logic [POS_W-1:0]           max_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic [POS_W-1:0]           max_pos_q;
	logic [POS_W-1:0]           min_pos_q;
	logic [ABS_ACC_W-1:0]       acc_abs_q;
	logic [SQR_ACC_W-1:0]       acc_sqr_q;
	logic [CUBE_ACC_W-1:0]      acc_cube_q;
	logic [QUAD_ACC_W-1:0]      acc_quad_q;
	logic                       blk_end_q;
	logic [MAG_W-1:0]           mag_q;
	logic [MUL_W-1:0]           sqr_q;
	logic [PROD_W-1:0]          prod_q;
	logic                       res_valid_q;

	logic [CFG_W-1:0]           lg;
	logic [POS_W:0]             period;
	logic [POS_W:0]             half;
	logic [POS_W:0]             pos_inc;
	logic signed [SAMPLE_W-1:0] s_in;
	logic [MAG_W-1:0]           mag_in;
	logic                       accept;
	logic                       out_free;
	logic                       load_out;
	logic                       clear_blk;
	logic [MUL_W-1:0]           op_a;
	logic [MUL_W-1:0]           op_b;
	logic [PROD_W-1:0]          prod;
	logic [QUAD_ACC_W-1:0]      quad_sum;

	// effective period: values below the minimum act as the minimum
	assign lg     = (period_log2_q < PERIOD_LOG2_MIN) ? PERIOD_LOG2_MIN : period_log2_q;
	assign period = (POS_W+1)'(1) << lg;
	assign half   = (POS_W+1)'(1) << (lg - CFG_W'(1));

	// restart wipes the stream at the accept edge, so count from zero then
	assign pos_inc = samples.restart ? (POS_W+1)'(1) : ({1'b0, pos_q} + (POS_W+1)'(1));

	// keep only the low SAMPLE_BITS bits, sign-extended
	assign s_in   = SAMPLE_W'(signed'(samples.sample[SAMPLE_BITS-1:0]));
	assign mag_in = s_in[SAMPLE_W-1] ? MAG_W'(-s_in) : MAG_W'(s_in);

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;

	assign out_free = !res_valid_q || results.ready;
	assign load_out = ((state_q == S_MUL3) && blk_end_q && out_free) ||
		((state_q == S_WAIT) && out_free);
	assign clear_blk = load_out;

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_MUL0: begin
				op_a = MUL_W'(mag_q);
				op_b = MUL_W'(mag_q);
			end
			S_MUL1: begin
				op_a = prod_q[MUL_W-1:0];
				op_b = MUL_W'(mag_q);
			end
			S_MUL2: begin
				op_a = sqr_q;
				op_b = sqr_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod     = op_a * op_b;
	assign quad_sum = acc_quad_q + QUAD_ACC_W'(prod_q >> QUAD_SHIFT);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_log2_q <= PERIOD_LOG2_RESET;
		end else if (cfg_we) begin
			period_log2_q <= cfg_wdata;
		end
	end

	// sequencer, stream position and block statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			warm_q     <= 1'b0;
			pos_q      <= '0;
			max_q      <= '0;
			min_q      <= '0;
			max_pos_q  <= '0;
			min_pos_q  <= '0;
			acc_abs_q  <= '0;
			acc_sqr_q  <= '0;
			acc_cube_q <= '0;
			acc_quad_q <= '0;
			blk_end_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!samples.restart && warm_q) begin
							// counted item: peaks and |x| sum now, powers later
							if (s_in > signed'({1'b0, max_q})) begin
								max_q     <= s_in[POS_W-1:0];
								max_pos_q <= pos_q;
							end else if (s_in < min_q) begin
								min_q     <= s_in;
								min_pos_q <= pos_q;
							end
							acc_abs_q <= acc_abs_q + ABS_ACC_W'(mag_in);
							blk_end_q <= (pos_inc >= period);
							pos_q     <= (pos_inc >= period) ? '0 : pos_inc[POS_W-1:0];
							state_q   <= S_MUL0;
						end else if (!samples.restart) begin
							// warm-up item, not used
							warm_q <= (pos_inc >= half);
							pos_q  <= (pos_inc >= half) ? '0 : pos_inc[POS_W-1:0];
						end else begin
							// restart: drop all progress; this item is the first warm-up item
							max_q      <= '0;
							min_q      <= '0;
							max_pos_q  <= '0;
							min_pos_q  <= '0;
							acc_abs_q  <= '0;
							acc_sqr_q  <= '0;
							acc_cube_q <= '0;
							acc_quad_q <= '0;
							warm_q     <= (pos_inc >= half);
							pos_q      <= (pos_inc >= half) ? '0 : pos_inc[POS_W-1:0];
						end
					end
				end
				S_MUL0: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					acc_sqr_q <= acc_sqr_q + SQR_ACC_W'(prod_q);
					state_q   <= S_MUL2;
				end
				S_MUL2: begin
					acc_cube_q <= acc_cube_q + CUBE_ACC_W'(prod_q >> CUBE_SHIFT);
					state_q    <= S_MUL3;
				end
				S_MUL3: begin
					if (!blk_end_q) begin
						acc_quad_q <= quad_sum;
						state_q    <= S_IDLE;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end else begin
						acc_quad_q <= quad_sum;
						state_q    <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// block done and handed to the output register: start a fresh block
			if (clear_blk) begin
				max_q      <= '0;
				min_q      <= '0;
				max_pos_q  <= '0;
				min_pos_q  <= '0;
				acc_abs_q  <= '0;
				acc_sqr_q  <= '0;
				acc_cube_q <= '0;
				acc_quad_q <= '0;
			end
		end
	end

	// datapath registers around the shared multiplier
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
		end
		if (state_q == S_MUL1) begin
			sqr_q <= prod_q[MUL_W-1:0];
		end
		if (state_q == S_MUL0 || state_q == S_MUL1 || state_q == S_MUL2) begin
			prod_q <= prod;
		end
	end

	// output register: holds one result while the next items are worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			results.peak_high         <= max_q;
			results.peak_low          <= min_q;
			results.peak_high_offset  <= max_pos_q;
			results.peak_low_offset   <= min_pos_q;
			results.sum_abs           <= acc_abs_q;
			results.sum_square        <= acc_sqr_q;
			results.sum_cube_scaled   <= acc_cube_q;
			results.sum_fourth_scaled <= (state_q == S_MUL3) ? quad_sum : acc_quad_q;
		end
	end

	assign results.valid = res_valid_q;

`ifndef SYNTHESIS
	// never overwrite an unread result
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!res_valid_q || results.ready))
		else $error("result register loaded while occupied");

	// magnitude stays within the multiplier operand range
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL0) |-> (mag_q <= MAG_W'(1 << (SAMPLE_W - 1))))
		else $error("sample magnitude out of range");

	// the first multiply step is always followed directly by the second
	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL0) |=> (state_q == S_MUL1))
		else $error("multiply sequence broken");

	// a result only appears after the last multiply step of a block end item
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_MUL3 || $past(state_q) == S_WAIT))
		else $error("result raised outside block end");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for audio_block_peak_and_moments: streams samples over the
// valid/ready channels and checks each block result against an in-bench predictor.
// Depends on abpm_pkg, abpm_in_if, abpm_out_if and the block's top level.
module testbench;
	import abpm_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE_TICKS = 10;   // a counted item runs through the multiply states; leave margin
	localparam int LONG_HOLD    = 300;  // receiver hold-off, long enough to back up the input

	// One block result as it leaves the result channel.
	typedef struct {
		logic [POS_W-1:0]           peak_high;
		logic signed [SAMPLE_W-1:0] peak_low;
		logic [POS_W-1:0]           peak_high_offset;
		logic [POS_W-1:0]           peak_low_offset;
		logic [ABS_ACC_W-1:0]       sum_abs;
		logic [SQR_ACC_W-1:0]       sum_square;
		logic [CUBE_ACC_W-1:0]      sum_cube_scaled;
		logic [QUAD_ACC_W-1:0]      sum_fourth_scaled;
	} block_stats_t;

	// Ways the result side can behave between stalls.
	typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

	// Tracks the block's stream state, predicts block results and checks them.
	class block_stats_scoreboard_t;
		logic [CFG_W-1:0] period_log2;
		bit               warm_done;
		int unsigned      pos;
		int               max_s;
		int               min_s;
		int unsigned      max_at;
		int unsigned      min_at;
		longint unsigned  abs_acc;
		longint unsigned  sq_acc;
		longint unsigned  cube_acc;
		longint unsigned  quad_acc;
		block_stats_t     expected_blocks[$];
		int               errors;

		function new();
			period_log2 = PERIOD_LOG2_RESET;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_block();
			max_s = 0;
			min_s = 0;
			max_at = 0;
			min_at = 0;
			abs_acc = 0;
			sq_acc = 0;
			cube_acc = 0;
			quad_acc = 0;
		endfunction

		function void clear_stream();
			warm_done = 1'b0;
			pos = 0;
			clear_block();
		endfunction

		function void set_period(logic [CFG_W-1:0] v);
			period_log2 = v;
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction

		// Advance the stream by one accepted sample; queue a result at block end.
		function void note_sample(logic signed [SAMPLE_W-1:0] s, bit restart);
			int unsigned     lg;
			int unsigned     span;
			int unsigned     half;
			int              sv;
			longint unsigned mag;
			longint unsigned mag2;
			block_stats_t    res;
			lg = (period_log2 < PERIOD_LOG2_MIN) ? PERIOD_LOG2_MIN : period_log2;
			span = 1 << lg;
			half = 1 << (lg - 1);
			sv = s;
			if (restart)
				clear_stream();
			if (!warm_done) begin
				if (pos + 1 >= half) begin
					warm_done = 1'b1;
					pos = 0;
				end else begin
					pos = pos + 1;
				end
				return;
			end
			// A new low is only looked at when the sample is not a new high.
			if (sv > max_s) begin
				max_s = sv;
				max_at = pos;
			end else if (sv < min_s) begin
				min_s = sv;
				min_at = pos;
			end
			mag = (sv < 0) ? longint'(-sv) : longint'(sv);
			mag2 = mag * mag;
			abs_acc += mag;
			sq_acc += mag2;
			cube_acc += (mag2 * mag) >> CUBE_SHIFT;
			quad_acc += (mag2 * mag2) >> QUAD_SHIFT;
			if (pos + 1 < span) begin
				pos = pos + 1;
				return;
			end
			res.peak_high = max_s[POS_W-1:0];
			res.peak_low = min_s[SAMPLE_W-1:0];
			res.peak_high_offset = max_at[POS_W-1:0];
			res.peak_low_offset = min_at[POS_W-1:0];
			res.sum_abs = abs_acc[ABS_ACC_W-1:0];
			res.sum_square = sq_acc[SQR_ACC_W-1:0];
			res.sum_cube_scaled = cube_acc[CUBE_ACC_W-1:0];
			res.sum_fourth_scaled = quad_acc[QUAD_ACC_W-1:0];
			expected_blocks.push_back(res);
			clear_block();
			pos = 0;
		endfunction

		function void compare_field(string name, longint e, longint a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(block_stats_t got);
			block_stats_t e;
			if (expected_blocks.size() == 0) begin
				$error("block result arrived with none outstanding");
				errors++;
				return;
			end
			e = expected_blocks.pop_front();
			compare_field("peak_high", longint'(e.peak_high), longint'(got.peak_high));
			compare_field("peak_low", longint'(e.peak_low), longint'(got.peak_low));
			compare_field("peak_high_offset", longint'(e.peak_high_offset),
				longint'(got.peak_high_offset));
			compare_field("peak_low_offset", longint'(e.peak_low_offset),
				longint'(got.peak_low_offset));
			compare_field("sum_abs", longint'(e.sum_abs), longint'(got.sum_abs));
			compare_field("sum_square", longint'(e.sum_square), longint'(got.sum_square));
			compare_field("sum_cube_scaled", longint'(e.sum_cube_scaled),
				longint'(got.sum_cube_scaled));
			compare_field("sum_fourth_scaled", longint'(e.sum_fourth_scaled),
				longint'(got.sum_fourth_scaled));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	bit               hold_request;
	int               cycle_count;

	block_stats_scoreboard_t board;

	abpm_in_if  in_ch ();
	abpm_out_if out_ch ();

	audio_block_peak_and_moments uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (in_ch),
		.results   (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops results.
	initial begin : watchdog
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Mix extremes and near-zero values into otherwise uniform samples.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7FFF;
			end
			2: begin
				return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			end
			default: begin
				return SAMPLE_W'($urandom());
			end
		endcase
	endfunction

	// Offer one item and hold it until accepted. Valid stays high on return so a
	// following call keeps the channel busy without a bubble.
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit restart);
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.restart <= restart;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note_sample(s, restart);
	endtask

	// Drop valid, wait for every outstanding result, then let the last item
	// drain out of the multiplier pipeline (warm-up items leave no trace).
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Write the period register; only call when the block is idle.
	task automatic write_period(logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_period(v);
	endtask

	// Random items in bursts with random gaps; steady phases run back to back.
	// Restarts are rare so most of the stream gets past the warm-up.
	task automatic run_random(int count, bit steady);
		int burst;
		bit restart;
		burst = $urandom_range(1, 24);
		for (int i = 0; i < count; i++) begin
			restart = ($urandom_range(0, 49) == 0);
			send_sample(pick_sample(), restart);
			if (!steady) begin
				burst--;
				if (burst == 0) begin
					in_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
					burst = $urandom_range(1, 24);
				end
			end
		end
	endtask

	// Result side: check every accepted item, then pick the next ready value.
	// The long hold-off is counted here, independent of the sender.
	initial begin : result_side
		rx_mode_t     mode;
		int           mode_left;
		int           hold_left;
		block_stats_t got;
		mode = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.peak_high = out_ch.peak_high;
				got.peak_low = out_ch.peak_low;
				got.peak_high_offset = out_ch.peak_high_offset;
				got.peak_low_offset = out_ch.peak_low_offset;
				got.sum_abs = out_ch.sum_abs;
				got.sum_square = out_ch.sum_square;
				got.sum_cube_scaled = out_ch.sum_cube_scaled;
				got.sum_fourth_scaled = out_ch.sum_fourth_scaled;
				board.check_result(got);
			end
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS: begin
						out_ch.ready <= 1'b1;
					end
					RX_COIN: begin
						out_ch.ready <= $urandom_range(0, 1);
					end
					RX_EVERY_FOURTH: begin
						out_ch.ready <= (mode_left % 4 != 0);
					end
					default: begin
						out_ch.ready <= ($urandom_range(0, 7) != 0);
					end
				endcase
			end
		end
	end

	initial begin : stimulus
		// Directed items at the shortest period (blocks of eight, warm-up of four).
		// First block: both extremes, then repeats of each extreme, which must not
		// move the offsets. Then a partial block cut short by a restart, four
		// warm-up items and a block with no positive sample at all.
		logic signed [SAMPLE_W-1:0] directed_samples [23];
		logic [CFG_W-1:0]           period_plan [12];
		directed_samples = '{
			16'sd0, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000, 16'sd0,
			16'sd100, -16'sd100, 16'sd3,
			16'sd7, 16'sd9, -16'sd9, 16'sd11,
			-16'sd1, -16'sd2, -16'sd3, 16'sh8000, -16'sd5, 16'sh8000, -16'sd7, -16'sd8
		};
		// Settings for the random phases. Zero to two act as the minimum; going from a
		// long period to a short one ends the running block with the next counted item.
		period_plan = '{4'd4, 4'd0, 4'd5, 4'd3, 4'd6, 4'd2, 4'd8, 4'd1, 4'd7, 4'd5,
			4'd4, 4'd3};

		board = new();
		hold_request = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.restart <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few items at the reset period stay inside its long warm-up. A short
		// reset value would end the warm-up and raise results that nothing expects.
		for (int i = 0; i < 16; i++)
			send_sample(pick_sample(), 1'b0);
		settle();
		write_period(PERIOD_LOG2_MIN);

		// Restart and run the four warm-up items so the directed block starts at zero.
		send_sample(pick_sample(), 1'b1);
		for (int i = 0; i < 3; i++)
			send_sample(pick_sample(), 1'b0);

		for (int i = 0; i < 23; i++)
			send_sample(directed_samples[i], i == 11);

		// Random phases; the period changes mid-stream, without a restart.
		foreach (period_plan[p]) begin
			settle();
			write_period(period_plan[p]);
			// Stall the result side early on so the block fills and backs up.
			if (p == 1)
				hold_request = 1'b1;
			run_random(74, p % 4 == 3);
		end

		// One block of sixteen: full-scale negative samples, then a final positive
		// peak that lands on the last offset.
		settle();
		write_period(4'd4);
		send_sample(pick_sample(), 1'b1);
		for (int i = 0; i < 7; i++)
			send_sample(pick_sample(), 1'b0);
		for (int i = 0; i < 15; i++)
			send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);

		settle();
		if (board.errors == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/abpm_pkg.sv
rtl/abpm_in_if.sv
rtl/abpm_out_if.sv
rtl/audio_block_peak_and_moments.sv
verif/testbench.sv
